>>> sv/sstf_pkg.sv
// Shared types and constants for the shortest-seek-time-first request scheduler.
// Used by the scheduler top level, its entry cells and the port checker.
package sstf_pkg;

    localparam int TRACK_W            = 10;
    localparam int REQ_W              = 4;
    localparam int CFG_W              = 5;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;
    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int DEF_MAX_REQUESTERS = 16;
    localparam int MAX_RESULTS        = 16;
    localparam int RES_W              = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_W-1:0] MAX_QUEUE_RST = 5'd16;

    // Result status codes.
    localparam logic [1:0] ST_SERVED = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    // Input actions.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RETIRE  = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_MAX_QUEUE = 1'b0;
    localparam logic REG_REQ_COUNT = 1'b1;

    typedef struct packed {
        logic               action;
        logic [REQ_W-1:0]   requester;
        logic [TRACK_W-1:0] track;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [REQ_W-1:0]   served_requester;
        logic [TRACK_W-1:0] served_track;
        logic               last;
    } rsp_item_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic age_up;
        logic remove;
    } cell_ctrl_t;

endpackage

>>> sv/sstf_disk_request_scheduler_core.sv
// Shortest-seek-time-first disk request scheduler: sequencer, masks and a row of entry cells.
// Depends on sstf_pkg and sstf_cell. A new input beat is taken only in the idle state, so
// each beat is worked off before the next is taken; a reject result passes through the hold
// and result registers. Each served entry takes a scan of the cell chain, one cell a cycle,
// then a remove step.
// Reset is asynchronous: queue empty, no requester live, max_queue 16, last track 0.
module sstf_disk_request_scheduler_core
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
    parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LIVE_W  = $clog2(MAX_REQUESTERS + 1);
    localparam int CAP_LIM = (QUEUE_DEPTH > MAX_REQUESTERS) ? QUEUE_DEPTH : MAX_REQUESTERS;
    localparam int CMP_W   = $clog2(((CAP_LIM > 31) ? CAP_LIM : 31) + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_REMOVE = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [IDX_W-1:0]          scan_cnt_reg, scan_cnt_next;
    logic [CFG_W-1:0]          max_queue_reg, max_queue_next;
    logic [CFG_W-1:0]          req_count_reg, req_count_next;
    logic [TRACK_W-1:0]        last_track_reg, last_track_next;
    logic [MAX_REQUESTERS-1:0] live_reg, live_next;
    logic [MAX_REQUESTERS-1:0] pending_reg, pending_next;
    logic [MAX_REQUESTERS-1:0] retiring_reg, retiring_next;
    logic [LIVE_W-1:0]         live_cnt_reg, live_cnt_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [RES_W-1:0]          res_cnt_reg, res_cnt_next;
    logic                      hold_valid_reg, hold_valid_next;
    rsp_item_t                 hold_reg, hold_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_item_t                 rsp_reg, rsp_next;

    logic [MAX_REQUESTERS-1:0] req_hit;
    logic [MAX_REQUESTERS-1:0] own_hit;
    logic                      live_hit;
    logic                      pending_hit;
    logic                      retiring_hit;
    logic [CMP_W-1:0]          cap;
    logic [CMP_W-1:0]          thr;
    logic [CMP_W-1:0]          rc_sat;
    logic                      more;
    logic                      out_space;
    logic                      cfg_wr;
    logic [IDX_W-1:0]          free_idx;
    logic                      free_found;

    logic [QUEUE_DEPTH-1:0]    cell_valid;
    cell_ctrl_t                cell_ctrl [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]      tok_found;
    logic [TRACK_W-1:0]        tok_dist  [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]          tok_order [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]          tok_idx   [QUEUE_DEPTH+1];
    logic [REQ_W-1:0]          tok_owner [QUEUE_DEPTH+1];
    logic [TRACK_W-1:0]        tok_track [QUEUE_DEPTH+1];

    // The head of the search chain always starts empty.
    assign tok_found[0] = 1'b0;
    assign tok_dist[0]  = '0;
    assign tok_order[0] = '0;
    assign tok_idx[0]   = '0;
    assign tok_owner[0] = '0;
    assign tok_track[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        sstf_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .ins_owner  (req.requester),
            .ins_track  (req.track),
            .rem_idx    (tok_idx[QUEUE_DEPTH]),
            .rem_order  (tok_order[QUEUE_DEPTH]),
            .last_track (last_track_reg),
            .tin_found  (tok_found[g]),
            .tin_dist   (tok_dist[g]),
            .tin_order  (tok_order[g]),
            .tin_idx    (tok_idx[g]),
            .tin_owner  (tok_owner[g]),
            .tin_track  (tok_track[g]),
            .tout_found (tok_found[g+1]),
            .tout_dist  (tok_dist[g+1]),
            .tout_order (tok_order[g+1]),
            .tout_idx   (tok_idx[g+1]),
            .tout_owner (tok_owner[g+1]),
            .tout_track (tok_track[g+1]),
            .valid      (cell_valid[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < MAX_REQUESTERS; i++)
        begin
            req_hit[i] = (32'(req.requester) == i);
            own_hit[i] = (32'(tok_owner[QUEUE_DEPTH]) == i);
        end
    end

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (!cell_valid[i] && !free_found)
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign live_hit     = |(live_reg & req_hit);
    assign pending_hit  = |(pending_reg & req_hit);
    assign retiring_hit = |(retiring_reg & req_hit);

    assign cap = (CMP_W'(max_queue_reg) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                               : CMP_W'(max_queue_reg);
    assign thr = (cap < CMP_W'(live_cnt_reg)) ? cap : CMP_W'(live_cnt_reg);
    assign more = (res_cnt_reg < RES_W'(MAX_RESULTS)) && (count_reg != '0)
                  && (CMP_W'(count_reg) >= thr);
    assign rc_sat = (CMP_W'(pwdata[CFG_W-1:0]) > CMP_W'(MAX_REQUESTERS))
                    ? CMP_W'(MAX_REQUESTERS) : CMP_W'(pwdata[CFG_W-1:0]);

    assign out_space = !rsp_valid_reg || rsp_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        max_queue_next  = max_queue_reg;
        req_count_next  = req_count_reg;
        last_track_next = last_track_reg;
        live_next       = live_reg;
        pending_next    = pending_reg;
        retiring_next   = retiring_reg;
        live_cnt_next   = live_cnt_reg;
        count_next      = count_reg;
        res_cnt_next    = res_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            cell_ctrl[i] = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_cnt_next    = '0;
                    hold_valid_next = 1'b0;
                    hold_next       = '0;
                    if (req.action == ACT_REQUEST)
                    begin
                        if (!live_hit || retiring_hit)
                        begin
                            hold_valid_next  = 1'b1;
                            hold_next.status = ST_BAD;
                        end
                        else if (pending_hit)
                        begin
                            hold_valid_next  = 1'b1;
                            hold_next.status = ST_DUP;
                        end
                        else if (CMP_W'(count_reg) >= cap)
                        begin
                            hold_valid_next  = 1'b1;
                            hold_next.status = ST_FULL;
                        end
                        else
                        begin
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                            begin
                                cell_ctrl[i].age_up = 1'b1;
                                cell_ctrl[i].insert = (free_idx == IDX_W'(i));
                            end
                            count_next   = count_reg + CNT_W'(1);
                            pending_next = pending_reg | req_hit;
                        end
                    end
                    else
                    begin
                        if (!live_hit)
                        begin
                            hold_valid_next  = 1'b1;
                            hold_next.status = ST_BAD;
                        end
                        else if (!retiring_hit)
                        begin
                            // A requester with a queued entry stays live until it is served.
                            if (pending_hit)
                            begin
                                retiring_next = retiring_reg | req_hit;
                            end
                            else
                            begin
                                live_next     = live_reg & ~req_hit;
                                live_cnt_next = live_cnt_reg - LIVE_W'(1);
                            end
                        end
                    end
                    if (hold_valid_next)
                        res_cnt_next = RES_W'(1);
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (hold_valid_reg)
                begin
                    if (out_space)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next        = hold_reg;
                        rsp_next.last   = !more;
                        hold_valid_next = 1'b0;
                        state_next      = more ? S_SCAN : S_IDLE;
                    end
                end
                else
                begin
                    state_next = more ? S_SCAN : S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = S_REMOVE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end

            S_REMOVE:
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    cell_ctrl[i].remove = 1'b1;
                count_next      = count_reg - CNT_W'(1);
                last_track_next = tok_track[QUEUE_DEPTH];
                pending_next    = pending_reg & ~own_hit;
                if (|(retiring_reg & own_hit))
                begin
                    retiring_next = retiring_reg & ~own_hit;
                    live_next     = live_reg & ~own_hit;
                    live_cnt_next = live_cnt_reg - LIVE_W'(1);
                end
                hold_valid_next            = 1'b1;
                hold_next.status           = ST_SERVED;
                hold_next.served_requester = tok_owner[QUEUE_DEPTH];
                hold_next.served_track     = tok_track[QUEUE_DEPTH];
                hold_next.last             = 1'b0;
                res_cnt_next               = res_cnt_reg + RES_W'(1);
                state_next                 = S_CHECK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            if (paddr[2] == REG_REQ_COUNT)
            begin
                req_count_next  = pwdata[CFG_W-1:0];
                live_cnt_next   = LIVE_W'(rc_sat);
                for (int i = 0; i < MAX_REQUESTERS; i++)
                    live_next[i] = (CMP_W'(i) < rc_sat);
                pending_next    = '0;
                retiring_next   = '0;
                count_next      = '0;
                last_track_next = '0;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    cell_ctrl[i].clear = 1'b1;
            end
            else
            begin
                max_queue_next = pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            max_queue_reg  <= MAX_QUEUE_RST;
            req_count_reg  <= '0;
            last_track_reg <= '0;
            live_reg       <= '0;
            pending_reg    <= '0;
            retiring_reg   <= '0;
            live_cnt_reg   <= '0;
            count_reg      <= '0;
            res_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            max_queue_reg  <= max_queue_next;
            req_count_reg  <= req_count_next;
            last_track_reg <= last_track_next;
            live_reg       <= live_next;
            pending_reg    <= pending_next;
            retiring_reg   <= retiring_next;
            live_cnt_reg   <= live_cnt_next;
            count_reg      <= count_next;
            res_cnt_reg    <= res_cnt_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_REQ_COUNT)
            prdata[CFG_W-1:0] = req_count_reg;
        else
            prdata[CFG_W-1:0] = max_queue_reg;
    end

    assign pready    = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/sstf_cell.sv
// One queue entry of the scheduler plus its stage of the nearest-track search chain.
// Depends on sstf_pkg for the track and requester widths and the control struct.
module sstf_cell
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [REQ_W-1:0]   ins_owner,
    input  logic [TRACK_W-1:0] ins_track,
    input  logic [IDX_W-1:0]   rem_idx,
    input  logic [IDX_W-1:0]   rem_order,
    input  logic [TRACK_W-1:0] last_track,
    input  logic               tin_found,
    input  logic [TRACK_W-1:0] tin_dist,
    input  logic [IDX_W-1:0]   tin_order,
    input  logic [IDX_W-1:0]   tin_idx,
    input  logic [REQ_W-1:0]   tin_owner,
    input  logic [TRACK_W-1:0] tin_track,
    output logic               tout_found,
    output logic [TRACK_W-1:0] tout_dist,
    output logic [IDX_W-1:0]   tout_order,
    output logic [IDX_W-1:0]   tout_idx,
    output logic [REQ_W-1:0]   tout_owner,
    output logic [TRACK_W-1:0] tout_track,
    output logic               valid
);

    logic               valid_reg, valid_next;
    logic [TRACK_W-1:0] track_reg, track_next;
    logic [REQ_W-1:0]   owner_reg, owner_next;
    logic [IDX_W-1:0]   order_reg, order_next;

    logic               tok_found_reg, tok_found_next;
    logic [TRACK_W-1:0] tok_dist_reg, tok_dist_next;
    logic [IDX_W-1:0]   tok_order_reg, tok_order_next;
    logic [IDX_W-1:0]   tok_idx_reg, tok_idx_next;
    logic [REQ_W-1:0]   tok_owner_reg, tok_owner_next;
    logic [TRACK_W-1:0] tok_track_reg, tok_track_next;

    logic [TRACK_W-1:0] seek;
    logic               take;

    assign seek = (track_reg >= last_track) ? (track_reg - last_track)
                                            : (last_track - track_reg);

    // Among equal seek distances the entry with the lower order is taken; orders are
    // unique, so the newest entry wins a tie.
    assign take = valid_reg && (!tin_found || (seek < tin_dist)
                  || ((seek == tin_dist) && (order_reg < tin_order)));

    always_comb
    begin
        valid_next = valid_reg;
        track_next = track_reg;
        owner_next = owner_reg;
        order_next = order_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            valid_next = 1'b1;
            track_next = ins_track;
            owner_next = ins_owner;
            order_next = '0;
        end
        else if (ctrl.age_up && valid_reg)
        begin
            order_next = order_reg + IDX_W'(1);
        end
        else if (ctrl.remove && valid_reg)
        begin
            if (rem_idx == IDX_W'(CELL_IDX))
                valid_next = 1'b0;
            else if (order_reg > rem_order)
                order_next = order_reg - IDX_W'(1);
        end
    end

    always_comb
    begin
        if (take)
        begin
            tok_found_next = 1'b1;
            tok_dist_next  = seek;
            tok_order_next = order_reg;
            tok_idx_next   = IDX_W'(CELL_IDX);
            tok_owner_next = owner_reg;
            tok_track_next = track_reg;
        end
        else
        begin
            tok_found_next = tin_found;
            tok_dist_next  = tin_dist;
            tok_order_next = tin_order;
            tok_idx_next   = tin_idx;
            tok_owner_next = tin_owner;
            tok_track_next = tin_track;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        track_reg     <= track_next;
        owner_reg     <= owner_next;
        order_reg     <= order_next;
        tok_found_reg <= tok_found_next;
        tok_dist_reg  <= tok_dist_next;
        tok_order_reg <= tok_order_next;
        tok_idx_reg   <= tok_idx_next;
        tok_owner_reg <= tok_owner_next;
        tok_track_reg <= tok_track_next;
    end

    assign valid      = valid_reg;
    assign tout_found = tok_found_reg;
    assign tout_dist  = tok_dist_reg;
    assign tout_order = tok_order_reg;
    assign tout_idx   = tok_idx_reg;
    assign tout_owner = tok_owner_reg;
    assign tout_track = tok_track_reg;

endmodule

>>> sv/sstf_checker.sv
// Port-level checks for the scheduler, attached to the top level by a bind statement.
// Depends on sstf_pkg for the result beat type and status codes.
module sstf_checker
    import sstf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    // A result beat that is not taken holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Reject beats carry no served entry.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_SERVED)
        |-> (rsp.served_requester == '0) && (rsp.served_track == '0))
        else $error("reject beat carries entry data");

    // While more results of the current item are due, no new item is taken.
    a_busy_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !req_ready)
        else $error("input taken while results still pending");

    // Each accepted input beat is worked on before the next one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind sstf_disk_request_scheduler_core sstf_checker u_sstf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
